[rtl/exposure_gain_update_assert.svh]
// Assertion macros used by egu_ctrl. Each expects clk and arst_n in scope.
`ifndef EXPOSURE_GAIN_UPDATE_ASSERT_SVH
`define EXPOSURE_GAIN_UPDATE_ASSERT_SVH

// Same-cycle implication
`define EGU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define EGU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/egu_pkg.sv]
package egu_pkg;

	// Configuration of the accumulation and the fixed-point format
	localparam int MAX_PIXELS_LOG2 = 22;
	localparam int EXP_FRAC_BITS   = 20;

	localparam int EXP_W  = 24;
	localparam int PIX_W  = 8;
	localparam int SQ_W   = 2 * PIX_W;
	localparam int DEN_W  = SQ_W + MAX_PIXELS_LOG2;
	localparam int NUM_W  = 64;
	localparam int PROD_W = EXP_W + PIX_W;
	localparam int SHL_W  = PIX_W + EXP_FRAC_BITS;
	localparam int ERR_W  = ((SHL_W > PROD_W) ? SHL_W : PROD_W) + 1;
	localparam int TERM_W = ERR_W + PIX_W + 1;
	localparam int REM_W  = DEN_W + EXP_W;
	localparam int CNT_W  = $clog2(EXP_W);

	localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(1048576);
	localparam logic [EXP_W-1:0] EXP_MAX   = {EXP_W{1'b1}};

	localparam logic signed [NUM_W-1:0] NUM_MAX = {1'b0, {(NUM_W-1){1'b1}}};
	localparam logic signed [NUM_W-1:0] NUM_MIN = -NUM_MAX;

	// Controller to datapath
	typedef struct packed {
		logic take;      // pixel request accepted this cycle
		logic prep;      // load magnitude and sign of the numerator
		logic rnd;       // add half the denominator for rounding
		logic chk;       // range check and divider setup
		logic div_step;  // one quotient bit
		logic emit;      // load result register, clear sums
	} egu_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_pend; // last pixel still in the pipeline
		logic last_done; // last pixel being summed this cycle
		logic div_last;  // final quotient bit this cycle
	} egu_sts_t;

endpackage

[rtl/exposure_gain_update.sv]
// Channel   Handshake              Payload
// --------  ---------------------  ----------------------------------------------
// pixel in  in_valid / in_ready    pixel_valid, intensity, albedo, last_pixel
// result    out_valid / out_ready  new_exposure, no_valid_data, saturated
// config    cfg_valid / cfg_ready  exposure_time
//
// Pixels are taken one per cycle while in_ready is high; each passes the stage 1
// and stage 2 registers before it is summed. After the last pixel: the pipeline,
// setup (prep, round, check), one quotient bit per divider step, then the result.
// New pixels are held off from the last pixel until the result is loaded.
// The result register holds off the result load only while the previous result waits.
// Reset sets exposure to 1.0 (1048576) and clears both sums.
module exposure_gain_update (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      pixel_valid,
	input  logic [egu_pkg::PIX_W-1:0] intensity,
	input  logic [egu_pkg::PIX_W-1:0] albedo,
	input  logic                      last_pixel,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [egu_pkg::EXP_W-1:0] new_exposure,
	output logic                      no_valid_data,
	output logic                      saturated,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [egu_pkg::EXP_W-1:0] exposure_time
);

	egu_pkg::egu_cmd_t cmd;
	egu_pkg::egu_sts_t sts;

	assign cfg_ready = 1'b1;

	egu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_pixel (last_pixel),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	egu_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid),
		.cfg_data      (exposure_time),
		.pixel_valid   (pixel_valid),
		.intensity     (intensity),
		.albedo        (albedo),
		.last_pixel    (last_pixel),
		.new_exposure  (new_exposure),
		.no_valid_data (no_valid_data),
		.saturated     (saturated)
	);

endmodule

[rtl/egu_datapath.sv]
module egu_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  egu_pkg::egu_cmd_t             cmd,
	output egu_pkg::egu_sts_t             sts,
	input  logic                          cfg_we,
	input  logic [egu_pkg::EXP_W-1:0]     cfg_data,
	input  logic                          pixel_valid,
	input  logic [egu_pkg::PIX_W-1:0]     intensity,
	input  logic [egu_pkg::PIX_W-1:0]     albedo,
	input  logic                          last_pixel,
	output logic [egu_pkg::EXP_W-1:0]     new_exposure,
	output logic                          no_valid_data,
	output logic                          saturated
);

	localparam int EXP_W  = egu_pkg::EXP_W;
	localparam int PIX_W  = egu_pkg::PIX_W;
	localparam int SQ_W   = egu_pkg::SQ_W;
	localparam int DEN_W  = egu_pkg::DEN_W;
	localparam int NUM_W  = egu_pkg::NUM_W;
	localparam int PROD_W = egu_pkg::PROD_W;
	localparam int SHL_W  = egu_pkg::SHL_W;
	localparam int ERR_W  = egu_pkg::ERR_W;
	localparam int TERM_W = egu_pkg::TERM_W;
	localparam int REM_W  = egu_pkg::REM_W;
	localparam int CNT_W  = egu_pkg::CNT_W;

	logic [EXP_W-1:0]         t_q;

	logic                     v_s1, pv_s1, last_s1;
	logic signed [ERR_W-1:0]  err_s1;
	logic [PIX_W-1:0]         alb_s1;

	logic                     v_s2, pv_s2, last_s2;
	logic signed [TERM_W-1:0] term_s2;
	logic [SQ_W-1:0]          sq_s2;

	logic signed [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]         den_q;

	logic [NUM_W-1:0]         dvd_q;
	logic                     neg_q, big_q;
	logic [REM_W-1:0]         rem_q;
	logic [REM_W-2:0]         dsh_q;
	logic [EXP_W-1:0]         quo_q;
	logic [CNT_W-1:0]         cnt_q;

	logic [PROD_W-1:0]        t_alb;
	logic [SHL_W-1:0]         inten_shl;
	logic signed [ERR_W-1:0]  err;
	logic signed [NUM_W:0]    num_sum;
	logic [DEN_W:0]           den_sum;
	logic [REM_W:0]           diff;
	logic [EXP_W:0]           t_plus;
	logic [EXP_W-1:0]         res;
	logic                     res_nv, res_sat;

	// Exposure register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= egu_pkg::EXP_RESET;
		end else if (cfg_we) begin
			t_q <= cfg_data;
		end
	end

	// Stage 1: error = (intensity << frac) - T * albedo
	assign t_alb     = PROD_W'(t_q) * PROD_W'(albedo);
	assign inten_shl = {intensity, {egu_pkg::EXP_FRAC_BITS{1'b0}}};
	assign err       = $signed(ERR_W'(inten_shl)) - $signed(ERR_W'(t_alb));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			pv_s1   <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.take;
			if (cmd.take) begin
				pv_s1   <= pixel_valid;
				last_s1 <= last_pixel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			err_s1 <= err;
			alb_s1 <= albedo;
		end
	end

	// Stage 2: error * albedo and albedo squared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			pv_s2   <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			if (v_s1) begin
				pv_s2   <= pv_s1;
				last_s2 <= last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			term_s2 <= TERM_W'(err_s1) * $signed(TERM_W'({1'b0, alb_s1}));
			sq_s2   <= SQ_W'(alb_s1) * SQ_W'(alb_s1);
		end
	end

	// Saturating accumulators
	assign num_sum = (NUM_W+1)'(num_q) + (NUM_W+1)'(term_s2);
	assign den_sum = {1'b0, den_q} + (DEN_W+1)'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			den_q <= '0;
		end else if (cmd.emit) begin
			num_q <= '0;
			den_q <= '0;
		end else if (v_s2 && pv_s2) begin
			if (num_sum > (NUM_W+1)'(egu_pkg::NUM_MAX)) begin
				num_q <= egu_pkg::NUM_MAX;
			end else if (num_sum < (NUM_W+1)'(egu_pkg::NUM_MIN)) begin
				num_q <= egu_pkg::NUM_MIN;
			end else begin
				num_q <= num_sum[NUM_W-1:0];
			end
			den_q <= den_sum[DEN_W] ? {DEN_W{1'b1}} : den_sum[DEN_W-1:0];
		end
	end

	// Divider: magnitude, rounding bias, range check, one quotient bit a cycle
	assign diff = {1'b0, rem_q} - (REM_W+1)'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.chk) begin
			cnt_q <= CNT_W'(EXP_W - 1);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			neg_q <= num_q[NUM_W-1];
			dvd_q <= num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
		end
		if (cmd.rnd) begin
			dvd_q <= dvd_q + NUM_W'(den_q >> 1);
		end
		if (cmd.chk) begin
			// quotient of 2^EXP_W or more always clips
			big_q <= dvd_q >= (NUM_W'(den_q) << EXP_W);
			rem_q <= dvd_q[REM_W-1:0];
			dsh_q <= {den_q, {(EXP_W-1){1'b0}}};
		end
		if (cmd.div_step) begin
			if (!diff[REM_W]) begin
				rem_q <= diff[REM_W-1:0];
			end
			quo_q <= {quo_q[EXP_W-2:0], ~diff[REM_W]};
			dsh_q <= dsh_q >> 1;
		end
	end

	// Final update with clipping
	assign t_plus = {1'b0, t_q} + {1'b0, quo_q};

	always_comb begin
		res     = t_q;
		res_nv  = 1'b0;
		res_sat = 1'b0;
		if (den_q == '0) begin
			res_nv = 1'b1;
		end else if (big_q) begin
			res_sat = 1'b1;
			res     = neg_q ? '0 : egu_pkg::EXP_MAX;
		end else if (neg_q) begin
			if (quo_q > t_q) begin
				res_sat = 1'b1;
				res     = '0;
			end else begin
				res = t_q - quo_q;
			end
		end else if (t_plus[EXP_W]) begin
			res_sat = 1'b1;
			res     = egu_pkg::EXP_MAX;
		end else begin
			res = t_plus[EXP_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			new_exposure  <= res;
			no_valid_data <= res_nv;
			saturated     <= res_sat;
		end
	end

	assign sts.last_pend = (v_s1 && last_s1) || (v_s2 && last_s2);
	assign sts.last_done = v_s2 && last_s2;
	assign sts.div_last  = (cnt_q == '0);

endmodule

[rtl/egu_ctrl.sv]
`include "exposure_gain_update_assert.svh"

module egu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_pixel,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output egu_pkg::egu_cmd_t cmd,
	input  egu_pkg::egu_sts_t sts
);

	typedef enum logic [5:0] {
		S_ACC  = 6'b000001,
		S_PREP = 6'b000010,
		S_RND  = 6'b000100,
		S_CHK  = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} egu_state_t;

	egu_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_ACC) && !sts.last_pend;

	// Commands
	assign cmd.take     = in_valid && in_ready;
	assign cmd.prep     = (state_q == S_PREP);
	assign cmd.rnd      = (state_q == S_RND);
	assign cmd.chk      = (state_q == S_CHK);
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.emit     = (state_q == S_FIN) && out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_ACC:   if (sts.last_done) state_d = S_PREP;
			S_PREP:  state_d = S_RND;
			S_RND:   state_d = S_CHK;
			S_CHK:   state_d = S_DIV;
			S_DIV:   if (sts.div_last) state_d = S_FIN;
			S_FIN:   if (out_free) state_d = S_ACC;
			default: state_d = S_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	`EGU_ASSERT_NEXT(a_last_blocks, in_valid && in_ready && last_pixel, !in_ready, "request taken after last pixel")
	`EGU_ASSERT_NEXT(a_div_to_fin, state_q == S_DIV && sts.div_last, state_q == S_FIN, "divider did not finish")
	`EGU_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_q || out_ready, "result overwritten")

endmodule
